[src/res_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// res_pkg
// Shared types and constants of the record exchange sorter.
// ----------------------------------------------------------------------------
package res_pkg;

    localparam int unsigned MAX_RECORDS_DEF = 16;
    localparam int unsigned PLATE_CHARS     = 8;

    // Configuration register indexes.
    localparam logic CFG_SORT_KEY   = 1'b0;
    localparam logic CFG_DESCENDING = 1'b1;

    // Sort key codes.
    localparam logic [1:0] KEY_ID    = 2'd0;
    localparam logic [1:0] KEY_BRAND = 2'd1;
    localparam logic [1:0] KEY_PLATE = 2'd2;
    localparam logic [1:0] KEY_NONE  = 2'd3;

    // Write data sources of the record store.
    localparam logic WR_SRC_IN  = 1'b0;
    localparam logic WR_SRC_CUR = 1'b1;

    typedef struct packed {
        logic [15:0] id;
        logic [15:0] owner;
        logic [2:0]  brand;
        logic [63:0] plate;
        logic        flag;
    } t_rec;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic wr_src;
        logic cur_load;
        logic emit;
        logic emit_last;
    } t_cmd;

    typedef struct packed {
        logic swap;
        logic no_sort;
    } t_sts;

endpackage
`default_nettype wire

[src/record_exchange_sorter.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// record_exchange_sorter
// Collects a run of records, exchange sorts them by the selected key and
// emits them in order.
//
//   Channel  | Handshake          | Payload
//   ---------+--------------------+--------------------------------------------
//   input    | start, busy        | i_car_id .. i_occupied, i_last_record
//   result   | o_valid (strobe)   | o_out_car_id .. o_out_occupied, o_out_last
//   config   | i_cfg_we           | i_cfg_idx, i_cfg_data
//
// Each start beat while idle stores one record, up to MAX_RECORDS. After the
// beat marked last, the run is sorted by reading and comparing one pair at a
// time through the single read port of the record store; with key mode three
// or a single record the sort is skipped. Results then follow back to back,
// each in the cycle after its read is issued. Busy is high from the last beat
// until the final read is issued. Reset is synchronous; the store is not
// cleared. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module record_exchange_sorter import res_pkg::*; #(
    parameter int unsigned MAX_RECORDS = MAX_RECORDS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [15:0] i_car_id,
    input  wire logic [15:0] i_owner_id,
    input  wire logic [2:0]  i_brand_code,
    input  wire logic [63:0] i_plate_text,
    input  wire logic        i_occupied,
    input  wire logic        i_last_record,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [1:0]  i_cfg_data,
    output logic             o_valid,
    output logic [15:0]      o_out_car_id,
    output logic [15:0]      o_out_owner_id,
    output logic [2:0]       o_out_brand_code,
    output logic [63:0]      o_out_plate_text,
    output logic             o_out_occupied,
    output logic             o_out_last
);

    localparam int unsigned AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;

    t_cmd          cmd;
    t_sts          sts;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    t_rec          in_rec;
    t_rec          out_rec;

    assign in_rec.id    = i_car_id;
    assign in_rec.owner = i_owner_id;
    assign in_rec.brand = i_brand_code;
    assign in_rec.plate = i_plate_text;
    assign in_rec.flag  = i_occupied;

    res_controller #(
        .MAX_RECORDS(MAX_RECORDS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_last_record(i_last_record),
        .busy         (busy),
        .i_sts        (sts),
        .o_cmd        (cmd),
        .o_rd_addr    (rd_addr),
        .o_wr_addr    (wr_addr)
    );

    res_datapath #(
        .MAX_RECORDS(MAX_RECORDS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_rd_addr (rd_addr),
        .i_wr_addr (wr_addr),
        .o_sts     (sts),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_rec     (in_rec),
        .o_valid   (o_valid),
        .o_rec     (out_rec),
        .o_last    (o_out_last)
    );

    assign o_out_car_id     = out_rec.id;
    assign o_out_owner_id   = out_rec.owner;
    assign o_out_brand_code = out_rec.brand;
    assign o_out_plate_text = out_rec.plate;
    assign o_out_occupied   = out_rec.flag;

endmodule
`default_nettype wire

[src/res_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// res_datapath
// Record store, current-record register, key comparator, configuration
// registers and result register.
// ----------------------------------------------------------------------------
module res_datapath import res_pkg::*; #(
    parameter int unsigned MAX_RECORDS = MAX_RECORDS_DEF,
    localparam int unsigned AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_cmd          i_cmd,
    input  wire logic [AW-1:0] i_rd_addr,
    input  wire logic [AW-1:0] i_wr_addr,
    output t_sts               o_sts,
    input  wire logic          i_cfg_we,
    input  wire logic          i_cfg_idx,
    input  wire logic [1:0]    i_cfg_data,
    input  wire t_rec          i_rec,
    output logic               o_valid,
    output t_rec               o_rec,
    output logic               o_last
);

    t_rec       r_mem [MAX_RECORDS];
    t_rec       r_rd;
    t_rec       r_cur;
    t_rec       n_wr_data;
    logic [1:0] r_sort_key;
    logic       r_descending;
    logic       r_out_vld;
    logic       r_out_last;
    logic       lt;
    logic       gt;

    function automatic logic [7:0] fold_lower(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A) begin
            return c + 8'h20;
        end
        return c;
    endfunction

    // Returns {less, greater}. The scan stops at the first differing byte or
    // at a shared terminating zero byte.
    function automatic logic [1:0] plate_cmp(input logic [63:0] a, input logic [63:0] b);
        logic       done;
        logic [1:0] res;
        logic [7:0] ca;
        logic [7:0] cb;
        done = 1'b0;
        res  = 2'b00;
        for (int k = 0; k < PLATE_CHARS; k++) begin
            ca = fold_lower(a[63-8*k -: 8]);
            cb = fold_lower(b[63-8*k -: 8]);
            if (!done) begin
                if (ca != cb) begin
                    done = 1'b1;
                    res  = (ca < cb) ? 2'b10 : 2'b01;
                end else if (ca == 8'h00) begin
                    done = 1'b1;
                end
            end
        end
        return res;
    endfunction

    always_comb begin
        unique case (r_sort_key)
            KEY_ID: begin
                lt = r_cur.id < r_rd.id;
                gt = r_cur.id > r_rd.id;
            end
            KEY_BRAND: begin
                lt = r_cur.brand < r_rd.brand;
                gt = r_cur.brand > r_rd.brand;
            end
            default: begin
                {lt, gt} = plate_cmp(r_cur.plate, r_rd.plate);
            end
        endcase
        o_sts.swap    = r_descending ? lt : gt;
        o_sts.no_sort = (r_sort_key == KEY_NONE);
        n_wr_data     = (i_cmd.wr_src == WR_SRC_CUR) ? r_cur : i_rec;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_wr_addr] <= n_wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
        if (i_cmd.cur_load) begin
            r_cur <= r_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sort_key   <= KEY_ID;
            r_descending <= 1'b0;
            r_out_vld    <= 1'b0;
            r_out_last   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_SORT_KEY:   r_sort_key   <= i_cfg_data;
                    CFG_DESCENDING: r_descending <= i_cfg_data[0];
                    default: ;
                endcase
            end
            r_out_vld  <= i_cmd.emit;
            r_out_last <= i_cmd.emit_last;
        end
    end

    assign o_valid = r_out_vld;
    assign o_rec   = r_rd;
    assign o_last  = r_out_last;

endmodule
`default_nettype wire

[src/res_controller.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// res_controller
// Sequencer for loading, exchange sorting and emitting the stored records.
// ----------------------------------------------------------------------------
module res_controller import res_pkg::*; #(
    parameter int unsigned MAX_RECORDS = MAX_RECORDS_DEF,
    localparam int unsigned AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1,
    localparam int unsigned CW = $clog2(MAX_RECORDS + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  wire logic          i_last_record,
    output logic               busy,
    input  wire t_sts          i_sts,
    output t_cmd               o_cmd,
    output logic [AW-1:0]      o_rd_addr,
    output logic [AW-1:0]      o_wr_addr
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_RD_I   = 3'd1;
    localparam logic [2:0] S_LD_CUR = 3'd2;
    localparam logic [2:0] S_RD_J   = 3'd3;
    localparam logic [2:0] S_CMP    = 3'd4;
    localparam logic [2:0] S_WB     = 3'd5;
    localparam logic [2:0] S_EMIT   = 3'd6;

    localparam logic [CW-1:0] FULL = CW'(MAX_RECORDS);
    localparam logic [CW-1:0] ONE  = CW'(1);
    localparam logic [CW-1:0] TWO  = CW'(2);

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_n, n_n;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_j, n_j;
    logic [CW-1:0] r_k, n_k;
    logic [CW-1:0] cnt_after;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_n       = r_n;
        n_i       = r_i;
        n_j       = r_j;
        n_k       = r_k;
        o_cmd     = '0;
        o_rd_addr = r_j[AW-1:0];
        o_wr_addr = r_j[AW-1:0];
        cnt_after = (r_count < FULL) ? r_count + ONE : r_count;

        unique case (r_state)
            S_IDLE: begin
                o_wr_addr    = r_count[AW-1:0];
                o_cmd.wr_src = WR_SRC_IN;
                if (start) begin
                    o_cmd.wr_en = (r_count < FULL);
                    n_count     = cnt_after;
                    if (i_last_record) begin
                        n_n     = cnt_after;
                        n_count = '0;
                        n_i     = '0;
                        n_j     = ONE;
                        n_k     = '0;
                        if (i_sts.no_sort || cnt_after < TWO) begin
                            n_state = S_EMIT;
                        end else begin
                            n_state = S_RD_I;
                        end
                    end
                end
            end
            S_RD_I: begin
                o_rd_addr   = r_i[AW-1:0];
                o_cmd.rd_en = 1'b1;
                n_state     = S_LD_CUR;
            end
            S_LD_CUR: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.cur_load = 1'b1;
                n_state        = S_CMP;
            end
            S_RD_J: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_CMP;
            end
            S_CMP: begin
                // On a swap the held record goes to slot j and slot j's record
                // becomes the one held for slot i.
                o_cmd.wr_en    = i_sts.swap;
                o_cmd.wr_src   = WR_SRC_CUR;
                o_cmd.cur_load = i_sts.swap;
                if (r_j + ONE < r_n) begin
                    n_j     = r_j + ONE;
                    n_state = S_RD_J;
                end else begin
                    n_state = S_WB;
                end
            end
            S_WB: begin
                o_wr_addr    = r_i[AW-1:0];
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_src = WR_SRC_CUR;
                if (r_i + TWO < r_n) begin
                    n_i     = r_i + ONE;
                    n_j     = r_i + TWO;
                    n_state = S_RD_I;
                end else begin
                    n_k     = '0;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                o_rd_addr       = r_k[AW-1:0];
                o_cmd.rd_en     = 1'b1;
                o_cmd.emit      = 1'b1;
                o_cmd.emit_last = (r_k + ONE == r_n);
                n_k             = r_k + ONE;
                if (r_k + ONE == r_n) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_n     <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_n     <= n_n;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule
`default_nettype wire
